>>> src/drns_pkg.sv
`default_nettype none

package drns_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CYL_W       = 14;
    localparam int TRK_W       = 14;
    localparam int SLOT_W      = 4;

    // Command codes carried by each input item
    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_REMOVE  = 2'd1,
        MODE_SEL_CYL = 2'd2,
        MODE_SEL_TRK = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [CYL_W-1:0]   cylinder;
        logic [TRK_W-1:0]   track;
        logic               direction;
        logic [SLOT_W-1:0]  slot;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  found_slot;
        logic [CYL_W-1:0]   found_cylinder;
        logic [TRK_W-1:0]   found_track;
        logic               any_beyond;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic               load;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> src/drns_ctrl.sv
`default_nettype none

module drns_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire drns_pkg::t_mode     i_mode,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output drns_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_TAIL = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [drns_pkg::IDX_W-1:0]  r_addr, n_addr;
    logic                        r_out_valid, n_out_valid;
    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last      = (r_addr == drns_pkg::IDX_W'(drns_pkg::TABLE_DEPTH - 1));

    // Sequence one item: scan the table (not for a remove), then commit and load the result
    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        o_cmd.load     = 1'b0;
        o_cmd.rd_en    = 1'b0;
        o_cmd.rd_addr  = r_addr;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_addr     = '0;
                    n_state    = (i_mode == drns_pkg::MODE_REMOVE) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_addr      = r_addr + 1'b1;
                if (w_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result flag until the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken item");
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN || r_state == S_FIN))
        else $error("accepted item did not start work");
    a_read_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_state == S_SCAN))
        else $error("table read outside scan");
    a_tail_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL) |=> (r_state == S_FIN))
        else $error("scan tail not followed by finish");
`endif

endmodule

`default_nettype wire

>>> src/drns_dp.sv
`default_nettype none

module drns_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire drns_pkg::t_in_item   i_in_item,
    input  wire drns_pkg::t_dp_cmd    i_cmd,
    output drns_pkg::t_out_item       o_out_item
);

    localparam int IDX_W = drns_pkg::IDX_W;
    localparam int CYL_W = drns_pkg::CYL_W;
    localparam int TRK_W = drns_pkg::TRK_W;

    typedef struct packed {
        logic [CYL_W-1:0] cyl;
        logic [TRK_W-1:0] trk;
    } t_entry;

    // Request store and valid marks
    t_entry                      r_mem [drns_pkg::TABLE_DEPTH];
    logic                        r_valid [drns_pkg::TABLE_DEPTH];

    drns_pkg::t_in_item          r_item;
    drns_pkg::t_out_item         r_out, n_out;

    // Read stage
    logic                        r_rd_live;
    logic [IDX_W-1:0]            r_rd_idx;
    logic                        r_rd_vld;
    t_entry                      r_rd_data;

    // Scan accumulators
    logic                        r_hit;
    logic [IDX_W-1:0]            r_hit_idx;
    logic [CYL_W-1:0]            r_best;
    t_entry                      r_best_ent;
    logic                        r_beyond;

    logic                        w_cand;
    logic                        w_better;
    logic                        w_beyond;
    logic [CYL_W-1:0]            w_dist;
    logic                        w_slot_ok;
    logic [IDX_W-1:0]            w_slot_idx;

    function automatic logic [CYL_W-1:0] absdiff(input logic [CYL_W-1:0] a,
                                                 input logic [CYL_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign w_slot_idx = IDX_W'(r_item.slot);
    assign w_slot_ok  = (32'(r_item.slot) < drns_pkg::TABLE_DEPTH) && r_valid[w_slot_idx];

    // Judge the entry in the read stage
    always_comb begin
        w_cand   = 1'b0;
        w_beyond = 1'b0;
        w_dist   = '0;
        w_better = 1'b0;
        unique case (r_item.mode)
            drns_pkg::MODE_INSERT: begin
                w_better = r_rd_live && !r_rd_vld && !r_hit;
            end
            drns_pkg::MODE_REMOVE: begin
                w_better = 1'b0;
            end
            drns_pkg::MODE_SEL_CYL: begin
                w_dist   = absdiff(r_rd_data.cyl, r_item.cylinder);
                w_beyond = r_item.direction ? (r_rd_data.cyl > r_item.cylinder)
                                            : (r_rd_data.cyl < r_item.cylinder);
                w_cand   = r_item.direction ? (r_rd_data.cyl >= r_item.cylinder)
                                            : (r_rd_data.cyl <= r_item.cylinder);
                w_better = r_rd_live && r_rd_vld && w_cand && (!r_hit || (w_dist < r_best));
            end
            drns_pkg::MODE_SEL_TRK: begin
                w_dist   = absdiff(r_rd_data.trk, r_item.track);
                w_better = r_rd_live && r_rd_vld && (!r_hit || (w_dist < r_best));
            end
        endcase
    end

    // Form the result from the scan outcome
    always_comb begin
        n_out = '0;
        n_out.status = drns_pkg::ST_EMPTY;
        unique case (r_item.mode) inside
            drns_pkg::MODE_INSERT: begin
                n_out.status     = r_hit ? drns_pkg::ST_OK : drns_pkg::ST_FULL;
                n_out.found_slot = r_hit ? drns_pkg::SLOT_W'(r_hit_idx) : '0;
            end
            drns_pkg::MODE_REMOVE: begin
                n_out.status     = w_slot_ok ? drns_pkg::ST_OK : drns_pkg::ST_EMPTY;
                n_out.found_slot = r_item.slot;
            end
            drns_pkg::MODE_SEL_CYL, drns_pkg::MODE_SEL_TRK: begin
                if (r_hit) begin
                    n_out.status         = drns_pkg::ST_OK;
                    n_out.found_slot     = drns_pkg::SLOT_W'(r_hit_idx);
                    n_out.found_cylinder = r_best_ent.cyl;
                    n_out.found_track    = r_best_ent.trk;
                end
                n_out.any_beyond = (r_item.mode == drns_pkg::MODE_SEL_CYL) && r_beyond;
            end
        endcase
    end

    // Read the store, fold entries and load the result
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= i_cmd.rd_addr;
        r_rd_vld  <= r_valid[i_cmd.rd_addr];
        r_rd_data <= r_mem[i_cmd.rd_addr];
        if (w_better) begin
            r_hit_idx  <= r_rd_idx;
            r_best     <= w_dist;
            r_best_ent <= r_rd_data;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // Write an inserted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_item.mode == drns_pkg::MODE_INSERT) && r_hit) begin
            r_mem[r_hit_idx] <= '{cyl: r_item.cylinder, trk: r_item.track};
        end
    end

    // Latch the item and keep the control flags of the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item    <= '0;
            r_rd_live <= 1'b0;
            r_hit     <= 1'b0;
            r_beyond  <= 1'b0;
        end else begin
            r_rd_live <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_item   <= i_in_item;
                r_hit    <= 1'b0;
                r_beyond <= 1'b0;
            end else begin
                if (w_better) begin
                    r_hit <= 1'b1;
                end
                if (r_rd_live && r_rd_vld && w_beyond) begin
                    r_beyond <= 1'b1;
                end
            end
        end
    end

    // Set or clear valid marks on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < drns_pkg::TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_cmd.commit) begin
            if ((r_item.mode == drns_pkg::MODE_INSERT) && r_hit) begin
                r_valid[r_hit_idx] <= 1'b1;
            end else if ((r_item.mode == drns_pkg::MODE_REMOVE) && w_slot_ok) begin
                r_valid[w_slot_idx] <= 1'b0;
            end
        end
    end

    assign o_out_item = r_out;

endmodule

`default_nettype wire

>>> src/disk_request_nearest_select_core.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_in_item  (drns_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_ready  | o_out_item (drns_pkg::t_out_item)
//
// Insert and both selects scan every table entry: the request store has one
// read port and the scan reads one entry per cycle. Remove skips the scan.
// One item is in work at a time.
// The result sits in an output register; a stalled output holds the finished
// item and blocks only the next commit. Reset clears every valid mark at once.
`default_nettype none

module disk_request_nearest_select_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire drns_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output drns_pkg::t_out_item       o_out_item
);

    drns_pkg::t_dp_cmd w_cmd;

    // Sequence each item
    drns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_in_item.mode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Hold the requests and run the search
    drns_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire
